[rtl/pfx_pkg.sv]
// Shared types, character codes and item classification for the postfix evaluator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pfx_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int VALUE_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int OUT_BITS        = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'

  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_DIGIT = 3'd1,
    K_ADD   = 3'd2,
    K_SUB   = 3'd3,
    K_MUL   = 3'd4,
    K_DIV   = 3'd5
  } op_kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] final_value;
    logic                       div_by_zero_seen;
  } out_item_t;

  // decoded item as it travels from front to back
  typedef struct packed {
    op_kind_t   kind;
    logic [3:0] digit;
    logic       last;
  } op_t;

  function automatic op_t classify(input in_item_t it);
    op_t        o;
    logic [7:0] d;
    d       = it.char_code - CH_ZERO;
    o.kind  = K_NONE;
    o.digit = d[3:0];
    o.last  = it.last_char;
    if (it.char_code inside {[CH_ZERO:CH_NINE]}) begin
      o.kind = K_DIGIT;
    end else begin
      case (it.char_code)
        CH_PLUS:  o.kind = K_ADD;
        CH_MINUS: o.kind = K_SUB;
        CH_STAR:  o.kind = K_MUL;
        CH_SLASH: o.kind = K_DIV;
        default:  o.kind = K_NONE;
      endcase
    end
    return o;
  endfunction

endpackage

[rtl/pfx_front.sv]
// Front end: accepts input items, decodes each character and queues the decoded op.
// Depends on pfx_pkg.
`timescale 1ns / 1ps

module pfx_front
  import pfx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_item,
  output logic     in_full,
  output logic     q_valid,
  output op_t      q_op,
  input  logic     q_pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  op_t           entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          do_wr, do_rd;

  assign in_full = (fill_r == CW'(QUEUE_DEPTH));
  assign q_valid = (fill_r != '0);
  assign q_op    = entry_r[rd_ptr_r];
  assign do_wr   = in_push && !in_full;
  assign do_rd   = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_wr && !do_rd) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= classify(in_item);
    end
  end

endmodule

[rtl/pfx_md.sv]
// Iterative multiply/divide unit: shift-add multiply, restoring signed divide,
// one bit per cycle. Depends on pfx_pkg.
`timescale 1ns / 1ps

module pfx_md
  import pfx_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  is_div,
  input  logic [VALUE_BITS-1:0] lhs,
  input  logic [VALUE_BITS-1:0] rhs,
  output logic                  done,
  output logic                  fault,
  output logic [VALUE_BITS-1:0] res
);

  localparam int W  = VALUE_BITS;
  localparam int NW = $clog2(W);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_RUN  = 3'b010,
    MD_FIX  = 3'b100
  } md_state_t;

  md_state_t     state_r, state_nxt;
  logic [W-1:0]  acc_r, acc_nxt;     // product, or partial remainder
  logic [W-1:0]  opa_r, opa_nxt;     // multiplicand, or dividend/quotient
  logic [W-1:0]  opb_r, opb_nxt;     // multiplier, or divisor
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          div_r, div_nxt;
  logic          neg_r, neg_nxt;
  logic          fault_r, fault_nxt;
  logic [W:0]    rem_sh, diff;
  logic [W-1:0]  lhs_mag, rhs_mag;

  assign lhs_mag = lhs[W-1] ? (~lhs + 1'b1) : lhs;
  assign rhs_mag = rhs[W-1] ? (~rhs + 1'b1) : rhs;
  assign rem_sh  = {acc_r, opa_r[W-1]};
  assign diff    = rem_sh - {1'b0, opb_r};

  assign done  = (state_r == MD_FIX);
  assign fault = fault_r;
  assign res   = !div_r ? acc_r : (neg_r ? (~opa_r + 1'b1) : opa_r);

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    opa_nxt   = opa_r;
    opb_nxt   = opb_r;
    cnt_nxt   = cnt_r;
    div_nxt   = div_r;
    neg_nxt   = neg_r;
    fault_nxt = fault_r;
    case (state_r)
      MD_IDLE: begin
        if (start) begin
          div_nxt   = is_div;
          acc_nxt   = '0;
          cnt_nxt   = NW'(W - 1);
          fault_nxt = 1'b0;
          neg_nxt   = 1'b0;
          if (!is_div) begin
            opa_nxt   = lhs;
            opb_nxt   = rhs;
            state_nxt = MD_RUN;
          end else if (rhs == '0) begin
            // divide by zero gives 0 and raises the fault
            opa_nxt   = '0;
            fault_nxt = 1'b1;
            state_nxt = MD_FIX;
          end else begin
            opa_nxt   = lhs_mag;
            opb_nxt   = rhs_mag;
            neg_nxt   = lhs[W-1] ^ rhs[W-1];
            state_nxt = MD_RUN;
          end
        end
      end
      MD_RUN: begin
        if (div_r) begin
          if (!diff[W]) begin
            acc_nxt = diff[W-1:0];
            opa_nxt = {opa_r[W-2:0], 1'b1};
          end else begin
            acc_nxt = rem_sh[W-1:0];
            opa_nxt = {opa_r[W-2:0], 1'b0};
          end
        end else begin
          if (opb_r[0]) begin
            acc_nxt = acc_r + opa_r;
          end
          opa_nxt = {opa_r[W-2:0], 1'b0};
          opb_nxt = {1'b0, opb_r[W-1:1]};
        end
        if (cnt_r == '0) begin
          state_nxt = MD_FIX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      MD_FIX: begin
        state_nxt = MD_IDLE;
      end
      default: begin
        state_nxt = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      fault_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fault_r <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    cnt_r <= cnt_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

endmodule

[rtl/pfx_back.sv]
// Back end: operand stack memory, op sequencer and the result register.
// Depends on pfx_pkg and pfx_md.
`timescale 1ns / 1ps

module pfx_back
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  op_t       q_op,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  localparam int W  = VALUE_BITS;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_POP_R = 8'b0000_0010,
    S_POP_L = 8'b0000_0100,
    S_EXEC  = 8'b0000_1000,
    S_WAIT  = 8'b0001_0000,
    S_PUSH  = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_FOUT  = 8'b1000_0000
  } back_state_t;

  back_state_t   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, cnt_dec;
  logic          flag_r, flag_nxt;
  op_t           op_r, op_nxt;
  logic          r_ok_r, r_ok_nxt;
  logic          l_ok_r, l_ok_nxt;
  logic          fin_ok_r, fin_ok_nxt;
  logic [W-1:0]  rhs_r, rhs_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic [W-1:0]  lhs;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r, out_item_nxt;

  logic [W-1:0]  stack_mem [STACK_DEPTH];
  logic [W-1:0]  mem_q_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr, top_addr;
  logic [W-1:0]  wr_data;

  logic          cnt_nz, cnt_full;
  logic          md_start, md_done, md_fault;
  logic [W-1:0]  md_res;

  assign cnt_nz    = (cnt_r != '0);
  assign cnt_full  = (cnt_r == CW'(STACK_DEPTH));
  assign cnt_dec   = cnt_r - 1'b1;
  assign top_addr  = cnt_dec[AW-1:0];
  assign lhs       = l_ok_r ? mem_q_r : '0;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  pfx_md #(
    .VALUE_BITS(VALUE_BITS)
  ) u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .is_div(op_r.kind == K_DIV),
    .lhs   (lhs),
    .rhs   (rhs_r),
    .done  (md_done),
    .fault (md_fault),
    .res   (md_res)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    flag_nxt      = flag_r;
    op_nxt        = op_r;
    r_ok_nxt      = r_ok_r;
    l_ok_nxt      = l_ok_r;
    fin_ok_nxt    = fin_ok_r;
    rhs_nxt       = rhs_r;
    res_nxt       = res_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;
    md_start      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = top_addr;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_data       = res_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          op_nxt = q_op;
          case (q_op.kind)
            K_DIGIT: begin
              wr_data = W'(q_op.digit);
              if (!cnt_full) begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
              state_nxt = q_op.last ? S_FIN : S_IDLE;
            end
            K_ADD, K_SUB, K_MUL, K_DIV: begin
              state_nxt = S_POP_R;
            end
            default: begin
              state_nxt = q_op.last ? S_FIN : S_IDLE;
            end
          endcase
        end
      end
      S_POP_R: begin
        rd_en    = 1'b1;
        r_ok_nxt = cnt_nz;
        if (cnt_nz) begin
          cnt_nxt = cnt_dec;
        end
        state_nxt = S_POP_L;
      end
      S_POP_L: begin
        rhs_nxt  = r_ok_r ? mem_q_r : '0;
        rd_en    = 1'b1;
        l_ok_nxt = cnt_nz;
        if (cnt_nz) begin
          cnt_nxt = cnt_dec;
        end
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (op_r.kind)
          K_ADD: begin
            res_nxt   = lhs + rhs_r;
            state_nxt = S_PUSH;
          end
          K_SUB: begin
            res_nxt   = lhs - rhs_r;
            state_nxt = S_PUSH;
          end
          default: begin
            md_start  = 1'b1;
            state_nxt = S_WAIT;
          end
        endcase
      end
      S_WAIT: begin
        if (md_done) begin
          res_nxt   = md_res;
          flag_nxt  = flag_r || md_fault;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!cnt_full) begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        state_nxt = op_r.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        rd_en      = 1'b1;
        fin_ok_nxt = cnt_nz;
        state_nxt  = S_FOUT;
      end
      S_FOUT: begin
        // wait for the result register to drain, then emit and clear the stack
        if (!out_valid_r) begin
          out_valid_nxt                 = 1'b1;
          out_item_nxt.final_value      = fin_ok_r ? OUT_BITS'($signed(mem_q_r)) : '0;
          out_item_nxt.div_by_zero_seen = flag_r;
          cnt_nxt                       = '0;
          flag_nxt                      = 1'b0;
          state_nxt                     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    r_ok_r     <= r_ok_nxt;
    l_ok_r     <= l_ok_nxt;
    fin_ok_r   <= fin_ok_nxt;
    rhs_r      <= rhs_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= stack_mem[rd_addr];
    end
  end

endmodule

[rtl/postfix_expression_evaluator_unit.sv]
// An accepted item is registered in the queue before the back end pops it. Digits and
// ignored characters finish on the pop; + and - pass POP_R, POP_L, EXEC and PUSH;
// * and / also wait on the one-bit-per-cycle md unit; a zero divisor skips its loop.
// A last character adds FIN and FOUT, plus any wait for the result register to drain.
// Input queue of 4 decoded items lets the front keep accepting while the back works.
// Reset (rst_n low, synchronous): queue, stack count, fault flag and result cleared.
`timescale 1ns / 1ps

module postfix_expression_evaluator_unit
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic q_valid;
  logic q_pop;
  op_t  q_op;

  pfx_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_push(in_push),
    .in_item(in_item),
    .in_full(in_full),
    .q_valid(q_valid),
    .q_op   (q_op),
    .q_pop  (q_pop)
  );

  pfx_back #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .q_pop    (q_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

endmodule

[rtl/pfx_chk.sv]
// Port-level checker for the postfix evaluator, bound to the top level.
// Depends on pfx_pkg.
`timescale 1ns / 1ps

module pfx_chk
  import pfx_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input in_item_t  in_item,
  input logic      in_full,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_item
);

  // expressions closed at the input but not yet popped at the output
  logic [3:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 4'(in_push && !in_full && in_item.last_char)
                       - 4'(out_pop && !out_empty);
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("waiting result changed or vanished");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> pend_r != '0)
    else $error("result without a closed expression");

  a_fault_needs_div: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) && out_item.div_by_zero_seen |-> pend_r != '0)
    else $error("division fault reported without a pending expression");

endmodule

bind postfix_expression_evaluator_unit pfx_chk u_pfx_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_push  (in_push),
  .in_item  (in_item),
  .in_full  (in_full),
  .out_empty(out_empty),
  .out_pop  (out_pop),
  .out_item (out_item)
);

[sim/postfix_expression_evaluator_unit_checker.sv]
// Scoreboard for the postfix evaluator: tracks the operand stack and compares the results.
// Depends on pfx_pkg for the item types and character codes.
`timescale 1ns / 1ps

module postfix_expression_evaluator_unit_checker
  import pfx_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  logic      in_full,
  input  in_item_t  in_item,
  input  logic      out_empty,
  input  logic      out_pop,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending_results
);

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int VB    = VALUE_BITS_DEF;

  logic [VB-1:0] rpn_stack [DEPTH];
  int            rpn_depth;
  bit            rpn_div_fault;
  out_item_t     expected_totals [$];
  int            errors = 0;

  assign fail_count = errors;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  function automatic op_kind_t char_kind(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return K_DIGIT;
    end
    case (c)
      CH_PLUS:  return K_ADD;
      CH_MINUS: return K_SUB;
      CH_STAR:  return K_MUL;
      CH_SLASH: return K_DIV;
      default:  return K_NONE;
    endcase
  endfunction

  // signed divide on magnitudes, truncating toward zero; min / -1 wraps to min
  function automatic logic [VB-1:0] trunc_quotient(input logic [VB-1:0] num,
                                                   input logic [VB-1:0] den);
    logic [VB-1:0] num_mag;
    logic [VB-1:0] den_mag;
    logic [VB-1:0] q;
    num_mag = num[VB-1] ? -num : num;
    den_mag = den[VB-1] ? -den : den;
    q = num_mag / den_mag;
    return (num[VB-1] ^ den[VB-1]) ? -q : q;
  endfunction

  task automatic stack_push(input logic [VB-1:0] v);
    if (rpn_depth < DEPTH) begin
      rpn_stack[rpn_depth] = v;
      rpn_depth++;
    end
  endtask

  // an empty stack yields zero
  task automatic stack_pop(output logic [VB-1:0] v);
    v = '0;
    if (rpn_depth > 0) begin
      rpn_depth--;
      v = rpn_stack[rpn_depth];
    end
  endtask

  task automatic rpn_apply(input in_item_t it);
    op_kind_t      kind;
    logic [VB-1:0] lhs;
    logic [VB-1:0] rhs;
    logic [VB-1:0] res;
    out_item_t     total;
    kind = char_kind(it.char_code);
    if (kind == K_DIGIT) begin
      stack_push(VB'(it.char_code - CH_ZERO));
    end else if (kind != K_NONE) begin
      stack_pop(rhs);
      stack_pop(lhs);
      case (kind)
        K_ADD: res = lhs + rhs;
        K_SUB: res = lhs - rhs;
        K_MUL: res = lhs * rhs;
        default: begin
          if (rhs == '0) begin
            rpn_div_fault = 1'b1;
            res = '0;
          end else begin
            res = trunc_quotient(lhs, rhs);
          end
        end
      endcase
      stack_push(res);
    end
    if (it.last_char) begin
      stack_pop(res);
      total.final_value      = res;
      total.div_by_zero_seen = rpn_div_fault;
      expected_totals.push_back(total);
      rpn_depth     = 0;
      rpn_div_fault = 1'b0;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      rpn_depth     = 0;
      rpn_div_fault = 1'b0;
      expected_totals.delete();
    end else begin
      // results first: a result can never come from the item taken at this same edge
      if (out_pop && !out_empty) begin
        if (expected_totals.size() == 0) begin
          report_mismatch($sformatf("result with none expected: value %0d, div0 %0b",
                                    out_item.final_value, out_item.div_by_zero_seen));
        end else begin
          want = expected_totals.pop_front();
          if (out_item.final_value !== want.final_value) begin
            report_mismatch($sformatf("final_value %0d, expected %0d",
                                      out_item.final_value, want.final_value));
          end
          if (out_item.div_by_zero_seen !== want.div_by_zero_seen) begin
            report_mismatch($sformatf("div_by_zero_seen %0b, expected %0b",
                                      out_item.div_by_zero_seen, want.div_by_zero_seen));
          end
        end
      end
      if (in_push && !in_full) begin
        rpn_apply(in_item);
      end
    end
    pending_results <= expected_totals.size();
  end

endmodule

[sim/postfix_expression_evaluator_unit_tb.sv]
// Top of the postfix evaluator testbench: clock, reset, character stimulus and result draining.
// Depends on pfx_pkg, the evaluator RTL and postfix_expression_evaluator_unit_checker.
`timescale 1ns / 1ps

module postfix_expression_evaluator_unit_tb;
  import pfx_pkg::*;

  localparam int ITEM_TARGET = 750;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 60;

  typedef enum int {
    POP_ALWAYS,
    POP_HALF,
    POP_MOSTLY,
    POP_EVERY4
  } pop_mode_t;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      in_push = 1'b0;
  in_item_t  in_item = '0;
  logic      out_pop = 1'b0;
  logic      in_full;
  logic      out_empty;
  out_item_t out_item;

  int fail_count;
  int pending_results;
  int items_sent  = 0;
  int burst_left  = 0;
  int cycle_count = 0;

  postfix_expression_evaluator_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  postfix_expression_evaluator_unit_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_item         (in_item),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_item        (out_item),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("postfix_expression_evaluator_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [7:0] digit(input int n);
    return 8'(CH_ZERO + n);
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic bit is_active(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE], CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  endfunction

  // any byte the evaluator skips
  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (is_active(c));
    return c;
  endfunction

  // offer one item, holding push high across bursts; gaps can open between bursts
  task automatic send_char(input logic [7:0] c, input logic lst);
    in_item_t it;
    int       gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 16);
    end
    it.char_code = c;
    it.last_char = lst;
    in_item <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // well-formed postfix with random digits and operators, last mark on the final item
  task automatic send_expression(input int operands);
    int         depth;
    int         left;
    logic [7:0] c;
    depth = 0;
    left  = operands;
    while (left > 0 || depth > 1) begin
      if (left > 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
        c = digit($urandom_range(0, 9));
        left--;
        depth++;
      end else begin
        c = pick_op();
        depth--;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_char(noise_byte(), 1'b0);
      end
      send_char(c, (left == 0 && depth <= 1));
    end
  endtask

  task automatic send_broken();
    int         len;
    logic [7:0] c;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 4))
        0, 1:    c = digit($urandom_range(0, 9));
        2, 3:    c = pick_op();
        default: c = noise_byte();
      endcase
      send_char(c, (i == len - 1) ? 1'($urandom_range(0, 1))
                                  : ($urandom_range(0, 5) == 0));
    end
  endtask

  initial begin
    int sel;
    int n;
    bit drained;
    drained = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-stack operator, empty expressions, byte extremes
    send_char(CH_PLUS, 1'b1);
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    // divide by zero, then check the flag clears
    send_char(digit(9), 1'b0);
    send_char(digit(0), 1'b0);
    send_char(CH_SLASH, 1'b1);
    send_char(digit(7), 1'b1);
    send_char(digit(3), 1'b0);
    send_char(digit(5), 1'b0);
    send_char(CH_MINUS, 1'b1);
    // last mark on an ignored byte after a product
    send_char(digit(9), 1'b0);
    send_char(digit(8), 1'b0);
    send_char(CH_STAR, 1'b0);
    send_char(8'h80, 1'b1);
    // -7 / 2 truncates to -3
    send_char(digit(0), 1'b0);
    send_char(digit(7), 1'b0);
    send_char(CH_MINUS, 1'b0);
    send_char(digit(2), 1'b0);
    send_char(CH_SLASH, 1'b1);
    // operator with a single operand on the stack
    send_char(digit(5), 1'b0);
    send_char(8'h61, 1'b0);
    send_char(CH_PLUS, 1'b1);

    // overfill the stack, then pop past empty
    for (int i = 0; i < 70; i++) begin
      send_char(digit($urandom_range(0, 9)), 1'b0);
    end
    for (int i = 0; i < 66; i++) begin
      send_char(CH_PLUS, (i == 65));
    end
    // 8^10 * 2 wraps to the most negative value, then divide by -1
    send_char(digit(8), 1'b0);
    repeat (9) begin
      send_char(digit(8), 1'b0);
      send_char(CH_STAR, 1'b0);
    end
    send_char(digit(2), 1'b0);
    send_char(CH_STAR, 1'b0);
    send_char(digit(0), 1'b0);
    send_char(digit(1), 1'b0);
    send_char(CH_MINUS, 1'b0);
    send_char(CH_SLASH, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        send_expression(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12));
      end else if (sel < 90) begin
        send_broken();
      end else begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
          send_char(noise_byte(), (i == n - 1) && ($urandom_range(0, 1) == 1));
        end
      end
      if (!drained && items_sent >= 450) begin
        drained = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("postfix_expression_evaluator_unit_tb: done, clean");
    end else begin
      $display("postfix_expression_evaluator_unit_tb: done, errors");
    end
    $finish;
  end

  // result side: changing stall pattern, plus one long hold-off to back up the input
  initial begin
    pop_mode_t mode;
    int        mode_left;
    int        hold_left;
    bit        held;
    mode      = POP_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (!held && items_sent >= 200) begin
        held      = 1'b1;
        hold_left = 400;
        out_pop <= 1'b0;
      end else begin
        if (mode_left <= 0) begin
          mode      = pop_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(30, 200);
        end
        mode_left--;
        case (mode)
          POP_ALWAYS: out_pop <= 1'b1;
          POP_HALF:   out_pop <= 1'($urandom_range(0, 1));
          POP_MOSTLY: out_pop <= ($urandom_range(0, 7) != 0);
          default:    out_pop <= (mode_left % 4 == 0);
        endcase
      end
    end
  end

endmodule

[sim.f]
rtl/pfx_pkg.sv
rtl/pfx_front.sv
rtl/pfx_md.sv
rtl/pfx_back.sv
rtl/postfix_expression_evaluator_unit.sv
rtl/pfx_chk.sv
sim/postfix_expression_evaluator_unit_checker.sv
sim/postfix_expression_evaluator_unit_tb.sv
